// ===== hdl/pib_pkg.sv =====
// Shared types and constants for the palette index builder.
// No dependencies; used by pib_cell and palette_index_builder.
package pib_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 256;
  localparam int unsigned CODE_W = 32;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned CNT_W = 9;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;

  // Probe that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic              active;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0]  new_idx;
    logic              resolved;
    logic              fresh;
    logic [IDX_W-1:0]  idx;
  } probe_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

endpackage

// ===== hdl/pib_cell.sv =====
// One palette table entry with its stage of the probe chain.
// Depends on pib_pkg (probe_t, widths).
module pib_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  pib_pkg::probe_t probe_i,
  output pib_pkg::probe_t probe_o
);
  import pib_pkg::*;

  logic              valid_q, valid_d;
  logic [CODE_W-1:0] code_q;
  logic [IDX_W-1:0]  idx_q;
  probe_t            probe_q, probe_d;
  logic              wr;

  always_comb begin
    probe_d = probe_i;
    wr      = 1'b0;
    if (probe_i.active && !probe_i.resolved) begin
      if (valid_q) begin
        if (code_q == probe_i.code) begin
          probe_d.resolved = 1'b1;
          probe_d.idx      = idx_q;
        end
      end else begin
        // first free entry: the color is new, take it here
        wr               = 1'b1;
        probe_d.resolved = 1'b1;
        probe_d.fresh    = 1'b1;
        probe_d.idx      = probe_i.new_idx;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (wr) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      probe_q <= '0;
    end else begin
      valid_q <= valid_d;
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      code_q <= probe_i.code;
      idx_q  <= probe_i.new_idx;
    end
  end

  assign probe_o = probe_q;

endmodule

// ===== hdl/palette_index_builder.sv =====
// Top level of the palette index builder: control, counters, output register
// and a chain of pib_cell entries. Depends on pib_pkg and pib_cell.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | sink      | in_valid_i / in_stall_o    | red, green, blue, alpha, end_of_image
//  out     | source    | out_valid_o / out_stall_i  | palette_index, new_entry,
//          |           |                            | color_count, overflow, image_done
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | alpha_enable
//
// For each pixel the probe steps through one cell per cycle over the whole
// chain, then the settling state updates the counters and loads the output
// register. Once overflow is set a pixel skips the chain and goes straight to
// the settling state. Reset clears the valid bit of every entry at once; the end
// of an image clears them the same way in the settling cycle. A stalled output
// holds the settling cycle, and the input stalls until the pixel is delivered
// into the output register.
module palette_index_builder #(
  parameter int unsigned PALETTE_ENTRIES = pib_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // pixel input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [pib_pkg::CHAN_W-1:0] red_i,
  input  logic [pib_pkg::CHAN_W-1:0] green_i,
  input  logic [pib_pkg::CHAN_W-1:0] blue_i,
  input  logic [pib_pkg::CHAN_W-1:0] alpha_i,
  input  logic                       end_of_image_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pib_pkg::IDX_W-1:0]  palette_index_o,
  output logic                       new_entry_o,
  output logic [pib_pkg::CNT_W-1:0]  color_count_o,
  output logic                       overflow_o,
  output logic                       image_done_o,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_alpha_enable_i
);
  import pib_pkg::*;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(PALETTE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] SAT_CNT  = CNT_W'(PALETTE_ENTRIES + 1);

  state_e            state_q, state_d;
  logic              alpha_en_q;
  logic [CNT_W-1:0]  dist_q, dist_d;
  logic [CNT_W-1:0]  asc_q, asc_d;
  logic              ovf_q, ovf_d;
  logic              desc_q, eoi_q;
  probe_t            tail_q;

  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  res_idx_q;
  logic              res_fresh_q, res_ovf_q, res_done_q;
  logic [CNT_W-1:0]  res_cnt_q;

  logic              in_accept, out_free, settle, clear;
  logic [CHAN_W-1:0] alpha_eff;
  logic              is_desc;
  logic [CODE_W-1:0] code;
  logic [CNT_W-1:0]  desc_used;
  logic [IDX_W-1:0]  new_idx;
  probe_t            head;
  probe_t            chain [PALETTE_ENTRIES+1];
  logic [IDX_W-1:0]  res_idx;
  logic              res_fresh;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_en_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      alpha_en_q <= cfg_alpha_enable_i;
    end
  end

  // Build the color code and the index a new color would take.
  always_comb begin
    alpha_eff = alpha_en_q ? alpha_i : ALPHA_OPAQUE;
    is_desc   = alpha_en_q && (alpha_eff == ALPHA_OPAQUE);
    if (alpha_en_q && (alpha_eff == ALPHA_CLEAR)) begin
      code = '0;   // every fully transparent pixel shares one code
    end else begin
      code = {red_i, green_i, blue_i, alpha_eff};
    end
    desc_used = dist_q - asc_q;
    // with alpha enabled, opaque colors count down from the top; all others count up from zero
    new_idx   = is_desc ? IDX_W'(LAST_IDX - desc_used) : IDX_W'(asc_q);
  end

  always_comb begin
    head          = '0;
    head.active   = in_accept && !ovf_q;
    head.code     = code;
    head.new_idx  = new_idx;
  end

  assign chain[0] = head;

  for (genvar gi = 0; gi < PALETTE_ENTRIES; gi++) begin : g_cell
    pib_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear),
      .probe_i (chain[gi]),
      .probe_o (chain[gi+1])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ovf_q ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (chain[PALETTE_ENTRIES].active) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    settle     = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_WALK:   in_stall_o = 1'b1;
      ST_FINISH: settle     = out_free;
      default:   in_stall_o = 1'b1;
    endcase
  end

  assign clear = settle && eoi_q;

  // Settle counters from the probe that left the chain.
  always_comb begin
    dist_d    = dist_q;
    asc_d     = asc_q;
    ovf_d     = ovf_q;
    res_idx   = tail_q.idx;
    res_fresh = tail_q.fresh;
    if (ovf_q || !tail_q.resolved) begin
      // no free entry left: saturate and stop inserting
      ovf_d     = 1'b1;
      dist_d    = SAT_CNT;
      res_idx   = '0;
      res_fresh = 1'b0;
    end else if (tail_q.fresh) begin
      dist_d = dist_q + CNT_W'(1);
      if (!desc_q) begin
        asc_d = asc_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dist_q  <= '0;
      asc_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear) begin
        dist_q <= '0;
        asc_q  <= '0;
        ovf_q  <= 1'b0;
      end else if (settle) begin
        dist_q <= dist_d;
        asc_q  <= asc_d;
        ovf_q  <= ovf_d;
      end
    end
  end

  // Hold per-pixel context for the settling cycle.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      desc_q <= is_desc;
      eoi_q  <= end_of_image_i;
    end
    if (in_accept && ovf_q) begin
      tail_q <= head;
    end else if (chain[PALETTE_ENTRIES].active) begin
      tail_q <= chain[PALETTE_ENTRIES];
    end
  end

  // Output register: load on settle, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (settle) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (settle) begin
      res_idx_q   <= res_idx;
      res_fresh_q <= res_fresh;
      res_cnt_q   <= dist_d;
      res_ovf_q   <= ovf_d;
      res_done_q  <= eoi_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign palette_index_o = res_idx_q;
  assign new_entry_o     = res_fresh_q;
  assign color_count_o   = res_cnt_q;
  assign overflow_o      = res_ovf_q;
  assign image_done_o    = res_done_q;

endmodule

// ===== verif/palette_index_builder_test.sv =====
// Self-checking testbench for palette_index_builder: directed pixel table, then random and wide images.
// Results are predicted per pixel and compared in order of arrival.
// Depends on pib_pkg and the palette_index_builder RTL only.
module palette_index_builder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pib_pkg::*;

  localparam int unsigned ENTRIES = PALETTE_ENTRIES_DEF;
  // Receiver hold-off that backs the block up into its input.
  localparam int unsigned LONG_HOLD = 1500;
  // A pixel walks the whole chain; allow for that plus the long hold, several times.
  localparam int unsigned QUIET_LIMIT = 8 * (LONG_HOLD + ENTRIES + 2);
  localparam int unsigned TAIL_CYCLES = 2 * ENTRIES + 100;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              eoi;
  } pixel_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             fresh;
    logic [CNT_W-1:0] count;
    logic             ovf;
    logic             done;
  } result_t;

  typedef enum logic [0:0] {
    STEP_PIXEL,
    STEP_SET_ALPHA
  } step_kind_e;

  typedef struct packed {
    step_kind_e kind;
    pixel_t     px;
    logic       alpha_en;  // value written by a STEP_SET_ALPHA row
    logic       typed;     // 1: use the typed result instead of the prediction
    result_t    want;
  } directed_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [CHAN_W-1:0]  red_i;
  logic [CHAN_W-1:0]  green_i;
  logic [CHAN_W-1:0]  blue_i;
  logic [CHAN_W-1:0]  alpha_i;
  logic               end_of_image_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [IDX_W-1:0]   palette_index_o;
  logic               new_entry_o;
  logic [CNT_W-1:0]   color_count_o;
  logic               overflow_o;
  logic               image_done_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_alpha_enable_i;

  palette_index_builder uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .red_i              (red_i),
    .green_i            (green_i),
    .blue_i             (blue_i),
    .alpha_i            (alpha_i),
    .end_of_image_i     (end_of_image_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .palette_index_o    (palette_index_o),
    .new_entry_o        (new_entry_o),
    .color_count_o      (color_count_o),
    .overflow_o         (overflow_o),
    .image_done_o       (image_done_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_alpha_enable_i (cfg_alpha_enable_i)
  );

  // Palette state as the block should hold it. Codes and indexes of entries
  // that are not marked used are never looked at.
  logic [CODE_W-1:0] palette_codes      [ENTRIES];
  logic [IDX_W-1:0]  palette_slot_index [ENTRIES];
  bit                palette_used       [ENTRIES];
  int unsigned       colors_seen;
  int unsigned       ascending_used;
  bit                palette_overflowed;
  bit                alpha_en_model = 1'b1;

  result_t     expected_results [$];
  int unsigned pixels_sent;
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned long_holds_asked;

  // Directed part. Typed results are the obvious ones; the rest go to the predictor.
  localparam directed_row_t DIRECTED_ROWS [21] = '{
    // alpha enabled after reset: transparent pixels all fold into code zero
    '{STEP_PIXEL, '{8'h12, 8'h34, 8'h56, 8'h00, 1'b0}, 1'b0, 1'b1, '{8'd0,   1'b1, 9'd1, 1'b0, 1'b0}},
    '{STEP_PIXEL, '{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0}, 1'b0, 1'b1, '{8'd0,   1'b0, 9'd1, 1'b0, 1'b0}},
    // opaque colors count down from the top
    '{STEP_PIXEL, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, 1'b1, '{8'd255, 1'b1, 9'd2, 1'b0, 1'b0}},
    '{STEP_PIXEL, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b0}, 1'b0, 1'b1, '{8'd254, 1'b1, 9'd3, 1'b0, 1'b0}},
    '{STEP_PIXEL, '{8'h80, 8'h80, 8'h80, 8'h80, 1'b0}, 1'b0, 1'b1, '{8'd1,   1'b1, 9'd4, 1'b0, 1'b0}},
    '{STEP_PIXEL, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, 1'b1, '{8'd255, 1'b0, 9'd4, 1'b0, 1'b0}},
    '{STEP_PIXEL, '{8'h00, 8'h00, 8'h00, 8'h01, 1'b0}, 1'b0, 1'b1, '{8'd2,   1'b1, 9'd5, 1'b0, 1'b0}},
    '{STEP_PIXEL, '{8'hFF, 8'hFF, 8'hFF, 8'hFE, 1'b0}, 1'b0, 1'b1, '{8'd3,   1'b1, 9'd6, 1'b0, 1'b0}},
    '{STEP_PIXEL, '{8'h00, 8'h00, 8'h00, 8'hFF, 1'b0}, 1'b0, 1'b1, '{8'd254, 1'b0, 9'd6, 1'b0, 1'b0}},
    // alpha off within the image: alpha is forced opaque, table kept
    '{STEP_SET_ALPHA, '0, 1'b0, 1'b0, '0},
    '{STEP_PIXEL, '{8'h00, 8'h00, 8'h00, 8'h5A, 1'b0}, 1'b0, 1'b1, '{8'd254, 1'b0, 9'd6, 1'b0, 1'b0}},
    '{STEP_PIXEL, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b0, 1'b1, '{8'd254, 1'b0, 9'd6, 1'b0, 1'b0}},
    '{STEP_PIXEL, '{8'hAA, 8'h55, 8'hAA, 8'h00, 1'b0}, 1'b0, 1'b1, '{8'd4,   1'b1, 9'd7, 1'b0, 1'b0}},
    '{STEP_PIXEL, '{8'h55, 8'hAA, 8'h55, 8'hFF, 1'b1}, 1'b0, 1'b1, '{8'd5,   1'b1, 9'd8, 1'b0, 1'b1}},
    // fresh image without alpha: new colors count up
    '{STEP_PIXEL, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, 1'b1, '{8'd0,   1'b1, 9'd1, 1'b0, 1'b0}},
    '{STEP_SET_ALPHA, '0, 1'b1, 1'b0, '0},
    '{STEP_PIXEL, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b0, 1'b1, '{8'd0,   1'b0, 9'd1, 1'b0, 1'b0}},
    '{STEP_PIXEL, '{8'h01, 8'h02, 8'h03, 8'hFF, 1'b0}, 1'b0, 1'b0, '0},
    '{STEP_PIXEL, '{8'h01, 8'h02, 8'h03, 8'h00, 1'b0}, 1'b0, 1'b0, '0},
    '{STEP_PIXEL, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, 1'b0, '0},
    // single-pixel image
    '{STEP_PIXEL, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}, 1'b0, 1'b1, '{8'd0,   1'b1, 9'd1, 1'b0, 1'b1}}
  };

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Work out the result of one pixel and advance the palette state.
  function automatic result_t map_pixel_to_index(input pixel_t px);
    result_t           res;
    logic [CHAN_W-1:0] a;
    logic [CODE_W-1:0] code;
    bit                found;
    res = '0;
    found = 1'b0;
    a = alpha_en_model ? px.alpha : ALPHA_OPAQUE;
    code = (alpha_en_model && a == ALPHA_CLEAR) ? '0 : {px.red, px.green, px.blue, a};
    if (!palette_overflowed) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && palette_used[i] && palette_codes[i] == code) begin
          res.idx = palette_slot_index[i];
          found = 1'b1;
        end
      end
      if (!found) begin
        if (colors_seen >= ENTRIES) begin
          // table full: flag overflow, saturate the count, insert nothing
          palette_overflowed = 1'b1;
          colors_seen = ENTRIES + 1;
        end else begin
          if (alpha_en_model && a == ALPHA_OPAQUE)
            res.idx = IDX_W'(ENTRIES - 1 - (colors_seen - ascending_used));
          else begin
            res.idx = IDX_W'(ascending_used);
            ascending_used++;
          end
          palette_codes[IDX_W'(colors_seen)] = code;
          palette_slot_index[IDX_W'(colors_seen)] = res.idx;
          palette_used[IDX_W'(colors_seen)] = 1'b1;
          colors_seen++;
          res.fresh = 1'b1;
        end
      end
    end
    if (palette_overflowed) begin
      res.idx = '0;
      res.fresh = 1'b0;
    end
    res.count = CNT_W'(colors_seen);
    res.ovf = palette_overflowed;
    res.done = px.eoi;
    if (px.eoi) begin
      palette_used = '{default: 1'b0};
      colors_seen = 0;
      ascending_used = 0;
      palette_overflowed = 1'b0;
    end
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.red = CHAN_W'($urandom);
    px.green = CHAN_W'($urandom);
    px.blue = CHAN_W'($urandom);
    px.alpha = CHAN_W'($urandom);
    px.eoi = 1'b0;
    return px;
  endfunction

  // Offer one pixel and hold it until the block takes it. Called and returns
  // at a falling edge; valid is left high so back-to-back items do not bubble.
  task automatic send_pixel(input pixel_t px, input bit typed, input result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= px.red;
    green_i <= px.green;
    blue_i <= px.blue;
    alpha_i <= px.alpha;
    end_of_image_i <= px.eoi;
    do @(posedge clk_i); while (in_stall_o);
    predicted = map_pixel_to_index(px);
    expected_results.insert(expected_results.size(), typed ? typed_res : predicted);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // Drain the block, then write alpha_enable.
  task automatic write_alpha_enable(input bit enable);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_alpha_enable_i <= enable;
    do @(posedge clk_i); while (!cfg_ready_o);
    alpha_en_model = enable;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Small-palette image: most pixels come from a pool so colors repeat.
  task automatic send_random_image();
    pixel_t      pool [16];
    pixel_t      px;
    int unsigned pool_size;
    int unsigned len;
    pool_size = $urandom_range(1, 16);
    len = ($urandom_range(9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 24);
    for (int i = 0; i < 16; i++) begin
      pool[i] = random_pixel();
      case ($urandom_range(3))
        0: pool[i].alpha = ALPHA_CLEAR;
        1: pool[i].alpha = ALPHA_OPAQUE;
        default: ;
      endcase
    end
    for (int unsigned p = 0; p < len; p++) begin
      // flip alpha_enable now and then in the middle of an image
      if ($urandom_range(59) == 0)
        write_alpha_enable(1'($urandom_range(1)));
      px = ($urandom_range(4) == 0) ? random_pixel() : pool[4'($urandom_range(pool_size - 1))];
      px.eoi = (p == len - 1);
      send_pixel(px, 1'b0, '0);
    end
    if ($urandom_range(3) == 0)
      write_alpha_enable(1'($urandom_range(1)));
  endtask

  // Image with many distinct colors to reach the full table and overflow.
  // The first pixels carry distinct codes: red and a green bit hold the
  // pixel number. The tail repeats them, plus fresh colors if asked.
  task automatic send_wide_image(input int unsigned distinct, input bit fresh_tail,
                                 input int unsigned tail);
    pixel_t seen_q [$];
    pixel_t px;
    for (int unsigned k = 0; k < distinct; k++) begin
      px = random_pixel();
      px.red = k[7:0];
      px.green[0] = k[8];
      px.alpha = $urandom_range(1) ? ALPHA_OPAQUE : CHAN_W'($urandom_range(1, 254));
      seen_q.insert(seen_q.size(), px);
      send_pixel(px, 1'b0, '0);
    end
    for (int unsigned k = 0; k < tail; k++) begin
      if (fresh_tail && $urandom_range(2) == 0)
        px = random_pixel();
      else
        px = seen_q[$urandom_range(seen_q.size() - 1)];
      px.eoi = (k == tail - 1);
      send_pixel(px, 1'b0, '0);
    end
  endtask

  // Receiver: random stall per cycle, or a long hold-off when one is asked.
  initial begin : result_drain
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left = 0;
    holds_done = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done != long_holds_asked) begin
        holds_done = long_holds_asked;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string field, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endtask

  // Compare every delivered result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no pixel pending: index %0d count %0d",
               palette_index_o, color_count_o);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("palette_index", CNT_W'(want.idx), CNT_W'(palette_index_o));
        check_field("new_entry", CNT_W'(want.fresh), CNT_W'(new_entry_o));
        check_field("color_count", want.count, color_count_o);
        check_field("overflow", CNT_W'(want.ovf), CNT_W'(overflow_o));
        check_field("image_done", CNT_W'(want.done), CNT_W'(image_done_o));
      end
    end
  end

  // Abort if no item moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    directed_row_t row;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    red_i = '0;
    green_i = '0;
    blue_i = '0;
    alpha_i = '0;
    end_of_image_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_alpha_enable_i = 1'b0;
    send_idle_pct = 31;
    recv_stall_pct = 59;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table.
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == STEP_SET_ALPHA)
        write_alpha_enable(row.alpha_en);
      else
        send_pixel(row.px, row.typed, row.want);
    end

    // Sender idles lightly, receiver stalls often.
    while (pixels_sent < 500)
      send_random_image();

    // Swap the pressure; fill the table exactly without overflowing it.
    send_idle_pct = 59;
    recv_stall_pct = 31;
    write_alpha_enable(1'b1);
    send_wide_image(ENTRIES, 1'b0, 12);
    while (pixels_sent < 1100)
      send_random_image();

    // Full rate; hold the receiver off long enough to back up the input,
    // then push one color past the table to set overflow.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_alpha_enable(1'b0);
    long_holds_asked++;
    send_wide_image(ENTRIES + 1, 1'b1, 30);
    while (pixels_sent < 2000)
      send_random_image();

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    // Let any stray result show up.
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
